FILE: rtl/tspd_pkg.sv
`default_nettype none

package tspd_pkg;

    // Packet geometry defaults
    localparam int PACKET_BYTES_DEF = 164;
    localparam int ROWS_DEF         = 60;
    localparam int COLUMNS_DEF      = 80;

    // Header and pixel layout
    localparam logic [3:0] DISCARD_NIBBLE   = 4'hF;
    localparam int         FIRST_PIXEL_POS  = 5;
    localparam int         ROW_POS          = 1;

    // Field widths fixed by the stream format
    localparam int BYTE_W   = 8;
    localparam int COLUMN_W = 7;
    localparam int LIMIT_W  = 16;

    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RESET = 16'd1000;
    localparam logic [LIMIT_W-1:0] MISS_COUNT_MAX   = 16'hFFFF;

    // One result beat
    typedef struct packed {
        logic                pixel_valid;
        logic [BYTE_W-1:0]   row_number;
        logic [COLUMN_W-1:0] column;
        logic [BYTE_W-1:0]   pixel;
        logic                packet_end;
        logic                packet_discarded;
        logic                frame_done;
        logic                gave_up;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/thermal_spi_packet_deframer.sv
`default_nettype none
// Channel   Handshake              Beat contents
// in        in_valid / in_stall    rx_byte, packet_start
// out       out_valid / out_stall  pixel_valid .. gave_up (one result)
// cfg       cfg_valid / cfg_ready  cfg_data = miss_limit
//
// One byte is taken per clock while in_stall is low; each byte passes the input
// register, then is decoded into a two-entry output queue whose head shows on out.
// Bytes that end no packet and carry no pixel produce no result beat.
// Reset clears the packet position, row, discard flag and miss count, and sets
// miss_limit to 1000. cfg_ready is always high.
// in_stall rises only when the output queue plus the byte in flight would fill
// it; a stall on out backs up into in after one buffered result.

module thermal_spi_packet_deframer
    import tspd_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int COLUMNS      = COLUMNS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input bytes
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    input  wire logic                packet_start,
    // results
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      logic                pixel_valid,
    output      logic [BYTE_W-1:0]   row_number,
    output      logic [COLUMN_W-1:0] column,
    output      logic [BYTE_W-1:0]   pixel,
    output      logic                packet_end,
    output      logic                packet_discarded,
    output      logic                frame_done,
    output      logic                gave_up,
    // configuration
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [LIMIT_W-1:0]  cfg_data
);

    logic               in_vld_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_start_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic       res_valid;
    result_t    res;
    result_t    head;
    logic       pop;
    logic [1:0] q_count;
    logic [2:0] occupancy;
    logic       in_accept;

    assign cfg_ready = 1'b1;
    assign pop       = out_valid && !out_stall;

    // Space check: queue entries plus byte in flight, less the one leaving
    assign occupancy = {1'b0, q_count} + {2'b0, in_vld_reg} - {2'b0, pop};
    assign in_stall  = (occupancy >= 3'd2);
    assign in_accept = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= packet_start;
        end
    end

    // Miss limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= MISS_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    tspd_core #(
        .PACKET_BYTES (PACKET_BYTES),
        .ROWS         (ROWS),
        .COLUMNS      (COLUMNS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_vld_reg),
        .item_byte  (in_byte_reg),
        .item_start (in_start_reg),
        .miss_limit (limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    tspd_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .head_valid (out_valid),
        .head       (head),
        .count      (q_count)
    );

    assign pixel_valid      = head.pixel_valid;
    assign row_number       = head.row_number;
    assign column           = head.column;
    assign pixel            = head.pixel;
    assign packet_end       = head.packet_end;
    assign packet_discarded = head.packet_discarded;
    assign frame_done       = head.frame_done;
    assign gave_up          = head.gave_up;

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && (q_count == 2'd2) && !pop))
        else $error("result queue overflow");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_count} + {2'b0, in_vld_reg}) <= 3'd2)
        else $error("queue plus byte in flight exceeds capacity");

    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_done || gave_up || packet_discarded) |->
            packet_end && !(frame_done && (gave_up || packet_discarded)))
        else $error("end report flags inconsistent");

endmodule

`default_nettype wire

FILE: rtl/tspd_core.sv
`default_nettype none

module tspd_core
    import tspd_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int COLUMNS      = COLUMNS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic [BYTE_W-1:0]  item_byte,
    input  wire logic               item_start,
    input  wire logic [LIMIT_W-1:0] miss_limit,
    output      logic               res_valid,
    output      result_t            res
);

    localparam int POS_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
    localparam logic [BYTE_W-1:0] ROWS_B     = BYTE_W'(ROWS);
    localparam logic [BYTE_W-1:0] LAST_ROW_B = BYTE_W'(ROWS - 1);
    localparam logic [8:0] COLUMNS_9 = 9'(COLUMNS);
    localparam logic [8:0] FIRST_PIX_9 = 9'(FIRST_PIXEL_POS);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               disc_reg, disc_next;
    logic [BYTE_W-1:0]  row_reg, row_next;
    logic [LIMIT_W-1:0] miss_reg, miss_next;

    logic [POS_W-1:0] pos;
    logic [8:0]       pos9;
    logic [8:0]       col9;
    logic             pix, last, done, gave;

    // Per-byte decode
    always_comb
    begin
        pos  = item_start ? '0 : pos_reg;
        pos9 = 9'(pos);
        col9 = (pos9 - FIRST_PIX_9) >> 1;

        disc_next = disc_reg;
        row_next  = row_reg;
        if (pos == '0)
        begin
            disc_next = (item_byte[3:0] == DISCARD_NIBBLE);
        end
        else if (pos9 == 9'(ROW_POS))
        begin
            row_next = item_byte;
        end

        // odd positions from the first pixel on carry pixel low bytes
        pix = (pos9 >= FIRST_PIX_9) && pos9[0] && !disc_next &&
              (row_next < ROWS_B) && (col9 < COLUMNS_9);

        last = (pos >= LAST_POS);
        done = last && !disc_next && (row_next == LAST_ROW_B);
        gave = 1'b0;

        miss_next = miss_reg;
        pos_next  = pos + 1'b1;
        if (last)
        begin
            pos_next = '0;
            if (done)
            begin
                miss_next = '0;
            end
            else if (miss_reg > miss_limit)
            begin
                gave      = 1'b1;
                miss_next = '0;
            end
            else if (miss_reg != MISS_COUNT_MAX)
            begin
                miss_next = miss_reg + 1'b1;
            end
        end

        res_valid            = item_valid && (pix || last);
        res.pixel_valid      = pix;
        res.row_number       = row_next;
        res.column           = pix ? col9[COLUMN_W-1:0] : '0;
        res.pixel            = pix ? item_byte : '0;
        res.packet_end       = last;
        res.packet_discarded = last && disc_next;
        res.frame_done       = done;
        res.gave_up          = gave;
    end

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            disc_reg <= 1'b0;
            row_reg  <= '0;
            miss_reg <= '0;
        end
        else if (item_valid)
        begin
            pos_reg  <= pos_next;
            disc_reg <= disc_next;
            row_reg  <= row_next;
            miss_reg <= miss_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tspd_out_queue.sv
`default_nettype none

module tspd_out_queue
    import tspd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output      logic    head_valid,
    output      result_t head,
    output      logic [1:0] count
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire
